>>> hdl/vet_pkg.sv
// shared widths, constants and item types of the error term solver
package vet_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned FRAC_W   = 24;
  localparam int unsigned MASK_W   = 5;
  localparam int unsigned FLAG_W   = 2;

  // measured mask bits
  localparam int unsigned MB_LOAD  = 0;
  localparam int unsigned MB_OPEN  = 1;
  localparam int unsigned MB_SHORT = 2;
  localparam int unsigned MB_THRU  = 3;
  localparam int unsigned MB_ISOL  = 4;

  // fallback flag bits
  localparam int unsigned FB_ES    = 0;
  localparam int unsigned FB_ET    = 1;

  localparam int unsigned DIFF_W   = DATA_W + 1;
  localparam int unsigned SUM_W    = DATA_W + 2;
  localparam int unsigned PROD_W   = 2 * SUM_W;
  localparam int unsigned ACC_W    = PROD_W + 1;
  localparam int unsigned DEN_W    = PROD_W;
  localparam int unsigned ES_NUM_W = PROD_W + FRAC_W;
  localparam int unsigned ET_NUM_W = DIFF_W + 2 * FRAC_W;
  localparam int unsigned NUM_W    = (ES_NUM_W > ET_NUM_W) ? ES_NUM_W : ET_NUM_W;
  localparam int unsigned CMP_W    =
    ((NUM_W > DEN_W + DATA_W) ? NUM_W : DEN_W + DATA_W) + 1;
  localparam int unsigned DIV_LAT  = DATA_W + 2;
  localparam int unsigned AR_W     = (FRAC_W + 2 > DATA_W + 1) ? FRAC_W + 2 : DATA_W + 1;
  localparam int unsigned P_W      = AR_W + DIFF_W + 1;
  localparam int unsigned SAT_W    = P_W + 1;

  localparam logic signed [DATA_W-1:0] MAX_V = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] MIN_V = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] ONE_V =
    (FRAC_W <= DATA_W - 2) ? (DATA_W'(1) << FRAC_W) : MAX_V;
  localparam logic signed [AR_W-1:0]   ONE_AR = AR_W'(1) << FRAC_W;

  typedef struct packed {
    logic signed [DATA_W-1:0] load_re;
    logic signed [DATA_W-1:0] load_im;
    logic signed [DATA_W-1:0] open_re;
    logic signed [DATA_W-1:0] open_im;
    logic signed [DATA_W-1:0] short_re;
    logic signed [DATA_W-1:0] short_im;
    logic signed [DATA_W-1:0] thru_re;
    logic signed [DATA_W-1:0] thru_im;
    logic signed [DATA_W-1:0] isol_re;
    logic signed [DATA_W-1:0] isol_im;
    logic                     last_point;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] ed_re;
    logic signed [DATA_W-1:0] ed_im;
    logic signed [DATA_W-1:0] es_re;
    logic signed [DATA_W-1:0] es_im;
    logic signed [DATA_W-1:0] er_re;
    logic signed [DATA_W-1:0] er_im;
    logic signed [DATA_W-1:0] et_inv_re;
    logic signed [DATA_W-1:0] et_inv_im;
    logic signed [DATA_W-1:0] ex_re;
    logic signed [DATA_W-1:0] ex_im;
    logic        [FLAG_W-1:0] fallback_flags;
    logic                     last_out;
  } out_t;

  // per item context that rides alongside the dividers
  typedef struct packed {
    logic signed [DATA_W-1:0] ed_re;
    logic signed [DATA_W-1:0] ed_im;
    logic signed [DATA_W-1:0] ex_re;
    logic signed [DATA_W-1:0] ex_im;
    logic signed [DIFF_W-1:0] o_re;
    logic signed [DIFF_W-1:0] o_im;
    logic signed [DIFF_W-1:0] s_re;
    logic signed [DIFF_W-1:0] s_im;
    logic                     op;
    logic                     sh;
    logic                     thm;
    logic                     es_zero;
    logic                     et_zero;
    logic                     last;
  } side_t;

  // divider operands, magnitude and sign form
  typedef struct packed {
    logic [NUM_W-1:0] es_num_re;
    logic [NUM_W-1:0] es_num_im;
    logic             es_neg_re;
    logic             es_neg_im;
    logic [NUM_W-1:0] et_num_re;
    logic [NUM_W-1:0] et_num_im;
    logic             et_neg_re;
    logic             et_neg_im;
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] sq;
  } front_t;

endpackage

>>> hdl/vet_in_if.sv
// input item channel
interface vet_in_if;
  logic          valid;
  logic          ready;
  vet_pkg::in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/vet_out_if.sv
// result item channel
interface vet_out_if;
  logic          valid;
  logic          ready;
  vet_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/vet_front.sv
// front pipeline: differences, products, sums and divider operands
module vet_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  vet_pkg::in_t                   data_i,
  input  logic [vet_pkg::MASK_W-1:0]     mask_i,
  output logic                           valid_o,
  output vet_pkg::side_t                 side_o,
  output vet_pkg::front_t                div_o
);

  logic [4:0] v_q;

  // stage 1
  vet_pkg::side_t side1_d, side1_q;
  logic signed [vet_pkg::DIFF_W-1:0] td_re1_d, td_im1_d, td_re1_q, td_im1_q;
  logic signed [vet_pkg::DATA_W-1:0] ed_re, ed_im, ex_re, ex_im;

  always_comb begin
    ed_re = mask_i[vet_pkg::MB_LOAD] ? data_i.load_re : '0;
    ed_im = mask_i[vet_pkg::MB_LOAD] ? data_i.load_im : '0;
    ex_re = mask_i[vet_pkg::MB_ISOL] ? data_i.isol_re : '0;
    ex_im = mask_i[vet_pkg::MB_ISOL] ? data_i.isol_im : '0;
    side1_d         = '0;
    side1_d.ed_re   = ed_re;
    side1_d.ed_im   = ed_im;
    side1_d.ex_re   = ex_re;
    side1_d.ex_im   = ex_im;
    side1_d.o_re    = vet_pkg::DIFF_W'(data_i.open_re) - vet_pkg::DIFF_W'(ed_re);
    side1_d.o_im    = vet_pkg::DIFF_W'(data_i.open_im) - vet_pkg::DIFF_W'(ed_im);
    side1_d.s_re    = vet_pkg::DIFF_W'(data_i.short_re) - vet_pkg::DIFF_W'(ed_re);
    side1_d.s_im    = vet_pkg::DIFF_W'(data_i.short_im) - vet_pkg::DIFF_W'(ed_im);
    side1_d.op      = mask_i[vet_pkg::MB_OPEN];
    side1_d.sh      = mask_i[vet_pkg::MB_SHORT];
    side1_d.thm     = mask_i[vet_pkg::MB_THRU];
    side1_d.last    = data_i.last_point;
    td_re1_d = vet_pkg::DIFF_W'(data_i.thru_re) - vet_pkg::DIFF_W'(ex_re);
    td_im1_d = vet_pkg::DIFF_W'(data_i.thru_im) - vet_pkg::DIFF_W'(ex_im);
  end

  // stage 2: sum and difference of the corrected open and short
  vet_pkg::side_t side2_q;
  logic signed [vet_pkg::SUM_W-1:0]  nr_q, ni_q, dr_q, di_q;
  logic signed [vet_pkg::DIFF_W-1:0] td_re2_q, td_im2_q;

  // stage 3: products
  vet_pkg::side_t side3_q;
  logic signed [vet_pkg::PROD_W-1:0] p_nrdr_q, p_nidi_q, p_nidr_q, p_nrdi_q;
  logic signed [vet_pkg::PROD_W-1:0] p_drdr_q, p_didi_q, p_ttr_q, p_tti_q;
  logic signed [vet_pkg::DIFF_W-1:0] td_re3_q, td_im3_q;
  logic signed [2*vet_pkg::DIFF_W-1:0] ttr, tti;

  assign ttr = td_re2_q * td_re2_q;
  assign tti = td_im2_q * td_im2_q;

  // stage 4: sums
  vet_pkg::side_t side4_q;
  logic signed [vet_pkg::ACC_W-1:0]  qr_q, qi_q;
  logic signed [vet_pkg::ACC_W-1:0]  den_s, sq_s;
  logic        [vet_pkg::DEN_W-1:0]  den_q, sq_q;
  logic signed [vet_pkg::DIFF_W-1:0] td_re4_q, td_im4_q;

  assign den_s = vet_pkg::ACC_W'(p_drdr_q) + vet_pkg::ACC_W'(p_didi_q);
  assign sq_s  = vet_pkg::ACC_W'(p_ttr_q) + vet_pkg::ACC_W'(p_tti_q);

  // stage 5: magnitudes and signs for the dividers
  vet_pkg::front_t div_d;
  vet_pkg::side_t  side5_d;
  logic [vet_pkg::ACC_W-1:0]  qr_abs, qi_abs;
  logic [vet_pkg::DIFF_W-1:0] tr_abs, ti_abs;

  always_comb begin
    qr_abs = qr_q[vet_pkg::ACC_W-1] ? -qr_q : qr_q;
    qi_abs = qi_q[vet_pkg::ACC_W-1] ? -qi_q : qi_q;
    tr_abs = td_re4_q[vet_pkg::DIFF_W-1] ? -td_re4_q : td_re4_q;
    ti_abs = td_im4_q[vet_pkg::DIFF_W-1] ? -td_im4_q : td_im4_q;
    div_d           = '0;
    div_d.es_num_re = vet_pkg::NUM_W'({qr_abs[vet_pkg::PROD_W-1:0],
                                        {vet_pkg::FRAC_W{1'b0}}});
    div_d.es_num_im = vet_pkg::NUM_W'({qi_abs[vet_pkg::PROD_W-1:0],
                                        {vet_pkg::FRAC_W{1'b0}}});
    div_d.es_neg_re = qr_q[vet_pkg::ACC_W-1];
    div_d.es_neg_im = qi_q[vet_pkg::ACC_W-1];
    div_d.et_num_re = vet_pkg::NUM_W'({tr_abs, {(2*vet_pkg::FRAC_W){1'b0}}});
    div_d.et_num_im = vet_pkg::NUM_W'({ti_abs, {(2*vet_pkg::FRAC_W){1'b0}}});
    div_d.et_neg_re = td_re4_q[vet_pkg::DIFF_W-1];
    // imaginary part of the inverse takes the negated difference
    div_d.et_neg_im = !td_im4_q[vet_pkg::DIFF_W-1] && (td_im4_q != '0);
    div_d.den       = den_q;
    div_d.sq        = sq_q;
    side5_d         = side4_q;
    side5_d.es_zero = (den_q == '0);
    side5_d.et_zero = (sq_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side1_q  <= side1_d;
      td_re1_q <= td_re1_d;
      td_im1_q <= td_im1_d;

      side2_q  <= side1_q;
      nr_q     <= vet_pkg::SUM_W'(side1_q.o_re) + vet_pkg::SUM_W'(side1_q.s_re);
      ni_q     <= vet_pkg::SUM_W'(side1_q.o_im) + vet_pkg::SUM_W'(side1_q.s_im);
      dr_q     <= vet_pkg::SUM_W'(side1_q.o_re) - vet_pkg::SUM_W'(side1_q.s_re);
      di_q     <= vet_pkg::SUM_W'(side1_q.o_im) - vet_pkg::SUM_W'(side1_q.s_im);
      td_re2_q <= td_re1_q;
      td_im2_q <= td_im1_q;

      side3_q  <= side2_q;
      p_nrdr_q <= nr_q * dr_q;
      p_nidi_q <= ni_q * di_q;
      p_nidr_q <= ni_q * dr_q;
      p_nrdi_q <= nr_q * di_q;
      p_drdr_q <= dr_q * dr_q;
      p_didi_q <= di_q * di_q;
      p_ttr_q  <= vet_pkg::PROD_W'(ttr);
      p_tti_q  <= vet_pkg::PROD_W'(tti);
      td_re3_q <= td_re2_q;
      td_im3_q <= td_im2_q;

      side4_q  <= side3_q;
      qr_q     <= vet_pkg::ACC_W'(p_nrdr_q) + vet_pkg::ACC_W'(p_nidi_q);
      qi_q     <= vet_pkg::ACC_W'(p_nidr_q) - vet_pkg::ACC_W'(p_nrdi_q);
      den_q    <= den_s[vet_pkg::DEN_W-1:0];
      sq_q     <= sq_s[vet_pkg::DEN_W-1:0];
      td_re4_q <= td_re3_q;
      td_im4_q <= td_im3_q;

      side_o   <= side5_d;
      div_o    <= div_d;
    end
  end

  assign valid_o = v_q[4];

endmodule

>>> hdl/vet_div.sv
// pipelined restoring divider, one quotient bit per stage, saturated signed result
module vet_div (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [vet_pkg::NUM_W-1:0]         num_i,
  input  logic [vet_pkg::DEN_W-1:0]         den_i,
  input  logic                              neg_i,
  output logic signed [vet_pkg::DATA_W-1:0] quo_o
);

  localparam int unsigned QW = vet_pkg::DATA_W;

  logic [vet_pkg::CMP_W-1:0] rem_q [QW+1];
  logic [vet_pkg::DEN_W-1:0] den_q [QW+1];
  logic [QW-1:0]             quo_q [QW+1];
  logic [QW:0]               neg_q;
  logic [QW:0]               ovf_q;

  // entry stage: quotients of 2^QW or more only saturate
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= vet_pkg::CMP_W'(num_i);
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      neg_q[0] <= neg_i;
      ovf_q[0] <= vet_pkg::CMP_W'(num_i) >= (vet_pkg::CMP_W'(den_i) << QW);
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_stage
    localparam int unsigned K = QW - j;
    logic [vet_pkg::CMP_W-1:0] trial;
    logic                      ge;
    assign trial = vet_pkg::CMP_W'(den_q[j-1]) << K;
    assign ge    = rem_q[j-1] >= trial;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= ge ? rem_q[j-1] - trial : rem_q[j-1];
        den_q[j] <= den_q[j-1];
        quo_q[j] <= quo_q[j-1] | (QW'(ge) << K);
        neg_q[j] <= neg_q[j-1];
        ovf_q[j] <= ovf_q[j-1];
      end
    end
  end

  logic [QW-1:0] q;
  logic          pos_big, neg_big;

  assign q       = quo_q[QW];
  assign pos_big = ovf_q[QW] || q[QW-1];
  assign neg_big = ovf_q[QW] || (q[QW-1] && (|q[QW-2:0]));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (neg_q[QW]) begin
        quo_o <= neg_big ? vet_pkg::MIN_V : -q;
      end else begin
        quo_o <= pos_big ? vet_pkg::MAX_V : q;
      end
    end
  end

endmodule

>>> hdl/vet_back.sv
// back pipeline: term selection, reflection tracking and result register
module vet_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  vet_pkg::side_t                    side_i,
  input  logic signed [vet_pkg::DATA_W-1:0] es_re_i,
  input  logic signed [vet_pkg::DATA_W-1:0] es_im_i,
  input  logic signed [vet_pkg::DATA_W-1:0] et_re_i,
  input  logic signed [vet_pkg::DATA_W-1:0] et_im_i,
  output logic                              valid_o,
  output vet_pkg::out_t                     data_o
);

  localparam int unsigned PA_W = vet_pkg::AR_W + vet_pkg::DIFF_W;

  function automatic logic signed [vet_pkg::DATA_W-1:0] sat_fn(
    input logic signed [vet_pkg::SAT_W-1:0] v);
    logic [vet_pkg::SAT_W-vet_pkg::DATA_W:0] top;
    top = v[vet_pkg::SAT_W-1:vet_pkg::DATA_W-1];
    if ((&top) || !(|top)) begin
      return v[vet_pkg::DATA_W-1:0];
    end
    return v[vet_pkg::SAT_W-1] ? vet_pkg::MIN_V : vet_pkg::MAX_V;
  endfunction

  logic [3:0] v_q;

  // stage 1: pick es and et, form 1 + es
  logic es_ok, et_ok;
  vet_pkg::side_t side1_q, side2_q, side3_q;
  logic signed [vet_pkg::DATA_W-1:0] es_re1_q, es_im1_q, et_re1_q, et_im1_q;
  logic signed [vet_pkg::DATA_W-1:0] es_re2_q, es_im2_q, et_re2_q, et_im2_q;
  logic signed [vet_pkg::DATA_W-1:0] es_re3_q, es_im3_q, et_re3_q, et_im3_q;
  logic signed [vet_pkg::AR_W-1:0]   ar1_q;
  logic [vet_pkg::FLAG_W-1:0] fl1_q, fl2_q, fl3_q;

  assign es_ok = side_i.op && side_i.sh && !side_i.es_zero;
  assign et_ok = side_i.thm && !side_i.et_zero;

  // stage 2: products (1 + es) * s'
  logic signed [PA_W-1:0] pa_q, pb_q, pc_q, pd_q;
  logic signed [vet_pkg::DATA_W+vet_pkg::DIFF_W-1:0] pb, pd;

  assign pb = es_im1_q * side1_q.s_im;
  assign pd = es_im1_q * side1_q.s_re;

  // stage 3: complex product
  logic signed [vet_pkg::P_W-1:0] pr_q, pi_q;

  // stage 4: er by mode
  logic signed [vet_pkg::P_W-1:0] pr_sh, pi_sh;
  logic signed [vet_pkg::DATA_W-1:0] er_re, er_im;
  vet_pkg::out_t out_d;

  assign pr_sh = pr_q >>> vet_pkg::FRAC_W;
  assign pi_sh = pi_q >>> vet_pkg::FRAC_W;

  always_comb begin
    if (side3_q.op && side3_q.sh) begin
      er_re = sat_fn(-vet_pkg::SAT_W'(pr_sh));
      er_im = sat_fn(-vet_pkg::SAT_W'(pi_sh));
    end else if (side3_q.op) begin
      er_re = sat_fn(vet_pkg::SAT_W'(side3_q.o_re));
      er_im = sat_fn(vet_pkg::SAT_W'(side3_q.o_im));
    end else if (side3_q.sh) begin
      er_re = sat_fn(-vet_pkg::SAT_W'(side3_q.s_re));
      er_im = sat_fn(-vet_pkg::SAT_W'(side3_q.s_im));
    end else begin
      er_re = vet_pkg::ONE_V;
      er_im = '0;
    end
    out_d                = '0;
    out_d.ed_re          = side3_q.ed_re;
    out_d.ed_im          = side3_q.ed_im;
    out_d.es_re          = es_re3_q;
    out_d.es_im          = es_im3_q;
    out_d.er_re          = er_re;
    out_d.er_im          = er_im;
    out_d.et_inv_re      = et_re3_q;
    out_d.et_inv_im      = et_im3_q;
    out_d.ex_re          = side3_q.ex_re;
    out_d.ex_im          = side3_q.ex_im;
    out_d.fallback_flags = fl3_q;
    out_d.last_out       = side3_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side1_q  <= side_i;
      es_re1_q <= es_ok ? es_re_i : '0;
      es_im1_q <= es_ok ? es_im_i : '0;
      et_re1_q <= et_ok ? et_re_i : vet_pkg::ONE_V;
      et_im1_q <= et_ok ? et_im_i : '0;
      ar1_q    <= vet_pkg::AR_W'($signed(es_ok ? es_re_i : '0)) + vet_pkg::ONE_AR;
      fl1_q[vet_pkg::FB_ES] <= side_i.op && side_i.sh && side_i.es_zero;
      fl1_q[vet_pkg::FB_ET] <= side_i.thm && side_i.et_zero;

      side2_q  <= side1_q;
      es_re2_q <= es_re1_q;
      es_im2_q <= es_im1_q;
      et_re2_q <= et_re1_q;
      et_im2_q <= et_im1_q;
      fl2_q    <= fl1_q;
      pa_q     <= ar1_q * side1_q.s_re;
      pb_q     <= PA_W'(pb);
      pc_q     <= ar1_q * side1_q.s_im;
      pd_q     <= PA_W'(pd);

      side3_q  <= side2_q;
      es_re3_q <= es_re2_q;
      es_im3_q <= es_im2_q;
      et_re3_q <= et_re2_q;
      et_im3_q <= et_im2_q;
      fl3_q    <= fl2_q;
      pr_q     <= vet_pkg::P_W'(pa_q) - vet_pkg::P_W'(pb_q);
      pi_q     <= vet_pkg::P_W'(pc_q) + vet_pkg::P_W'(pd_q);

      data_o   <= out_d;
    end
  end

  assign valid_o = v_q[3];

endmodule

>>> hdl/vna_error_term_compute.sv
// top level of the one-port error term solver with thru and isolation terms
//
// one frequency point per item: from the load, open, short, thru and isolation
// measurements (signed Q8.24) the block forms ed, es, er, ex and the inverse of
// et, saturated to 32 bits, picking defaults for standards that measured_mask
// marks as missing. it accepts one item every clock cycle while no result is
// held at the output, and passes each result through 5 front stages
// (corrections, products, sums, magnitudes), 34 stages of each long divider
// (one quotient bit per stage, which sets the latency), and 4 back stages
// that form er and register the result. the whole pipeline advances together;
// while a result waits at the output, in_i.ready drops but nothing in flight
// is lost. measured_mask is written through cfg_we_i / cfg_wdata_i and should
// change only while no item is in flight.
module vna_error_term_compute (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [vet_pkg::MASK_W-1:0]   cfg_wdata_i,
  vet_in_if.sink                       in_i,
  vet_out_if.source                    out_o
);

  logic [vet_pkg::MASK_W-1:0] mask_q;
  logic                       pipe_en;

  // everything steps together unless a finished result is held at the output
  assign pipe_en  = !out_o.valid || out_o.ready;
  assign in_i.ready = pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (cfg_we_i) begin
      mask_q <= cfg_wdata_i;
    end
  end

  // front: corrected standards, products and divider operands
  logic            front_vld;
  vet_pkg::side_t  front_side;
  vet_pkg::front_t front_div;

  vet_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (in_i.valid),
    .data_i  (in_i.data),
    .mask_i  (mask_q),
    .valid_o (front_vld),
    .side_o  (front_side),
    .div_o   (front_div)
  );

  // four dividers: es shares den, et_inv shares |thru - ex|^2
  logic signed [vet_pkg::DATA_W-1:0] es_re, es_im, et_re, et_im;

  vet_div u_div_es_re (
    .clk_i (clk_i), .en_i (pipe_en),
    .num_i (front_div.es_num_re), .den_i (front_div.den),
    .neg_i (front_div.es_neg_re), .quo_o (es_re)
  );

  vet_div u_div_es_im (
    .clk_i (clk_i), .en_i (pipe_en),
    .num_i (front_div.es_num_im), .den_i (front_div.den),
    .neg_i (front_div.es_neg_im), .quo_o (es_im)
  );

  vet_div u_div_et_re (
    .clk_i (clk_i), .en_i (pipe_en),
    .num_i (front_div.et_num_re), .den_i (front_div.sq),
    .neg_i (front_div.et_neg_re), .quo_o (et_re)
  );

  vet_div u_div_et_im (
    .clk_i (clk_i), .en_i (pipe_en),
    .num_i (front_div.et_num_im), .den_i (front_div.sq),
    .neg_i (front_div.et_neg_im), .quo_o (et_im)
  );

  // context and valid bits follow the items through the divider stages
  vet_pkg::side_t              side_q [vet_pkg::DIV_LAT];
  logic [vet_pkg::DIV_LAT-1:0] div_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_vld_q <= '0;
    end else if (pipe_en) begin
      div_vld_q <= {div_vld_q[vet_pkg::DIV_LAT-2:0], front_vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      side_q[0] <= front_side;
      for (int i = 1; i < vet_pkg::DIV_LAT; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // back: defaults, er and the result register
  vet_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (div_vld_q[vet_pkg::DIV_LAT-1]),
    .side_i  (side_q[vet_pkg::DIV_LAT-1]),
    .es_re_i (es_re),
    .es_im_i (es_im),
    .et_re_i (et_re),
    .et_im_i (et_im),
    .valid_o (out_o.valid),
    .data_o  (out_o.data)
  );

  // a zero es denominator must leave es at zero
  a_es_fallback : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.fallback_flags[vet_pkg::FB_ES] |->
      out_o.data.es_re == '0 && out_o.data.es_im == '0)
    else $error("es not zero on es fallback");

  // a zero et denominator must give the unit default
  a_et_fallback : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.fallback_flags[vet_pkg::FB_ET] |->
      out_o.data.et_inv_re == vet_pkg::ONE_V && out_o.data.et_inv_im == '0)
    else $error("et_inv not default on et fallback");

  // items in the divider section hold still while the pipeline is stalled
  a_div_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(div_vld_q))
    else $error("divider valid bits moved during stall");

endmodule
